@@ src/sdx_pkg.sv @@
// shared types, constants and the letter code table for the soundex word coder
// no dependencies
package sdx_pkg;

  // longest word kept; the byte after a full word is consumed and dropped
  localparam int unsigned MaxWord = 30;
  localparam int unsigned CountW = $clog2(MaxWord + 1);

  localparam int unsigned ByteW = 8;
  localparam int unsigned CharW = 7;
  localparam int unsigned CodeW = 3;
  localparam int unsigned LenW = 5;
  localparam int unsigned NumDigits = 4;
  localparam int unsigned FillW = $clog2(NumDigits + 1);

  // result of looking at one byte
  typedef struct packed {
    logic             is_letter;
    logic [CharW-1:0] lower;
    logic [CodeW-1:0] code;
  } sdx_class_t;

  // one finished word
  typedef struct packed {
    logic [CharW-1:0] first_letter;
    logic [CodeW-1:0] digit_one;
    logic [CodeW-1:0] digit_two;
    logic [CodeW-1:0] digit_three;
    logic [CodeW-1:0] digit_four;
    logic [LenW-1:0]  letter_count;
  } sdx_result_t;

  // soundex digit of a letter, a..z as 0..25 (01230120022455012623010202)
  function automatic logic [CodeW-1:0] letter_code(input logic [4:0] idx);
    logic [CodeW-1:0] c;
    case (idx)
      5'd1, 5'd5, 5'd15, 5'd21:                         c = 3'd1;
      5'd2, 5'd6, 5'd9, 5'd10, 5'd16, 5'd18, 5'd23, 5'd25: c = 3'd2;
      5'd3, 5'd19:                                       c = 3'd3;
      5'd11:                                             c = 3'd4;
      5'd12, 5'd13:                                      c = 3'd5;
      5'd17:                                             c = 3'd6;
      default:                                           c = 3'd0;
    endcase
    return c;
  endfunction

endpackage

@@ src/sdx_if.sv @@
// valid/ready channel interfaces for the soundex word coder
// depends on sdx_pkg
interface sdx_char_if;
  import sdx_pkg::*;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] text_byte;
  logic             end_marker;

  modport source (output valid, output text_byte, output end_marker, input ready);
  modport sink (input valid, input text_byte, input end_marker, output ready);
endinterface

interface sdx_code_if;
  import sdx_pkg::*;
  logic             valid;
  logic             ready;
  logic [CharW-1:0] first_letter;
  logic [CodeW-1:0] digit_one;
  logic [CodeW-1:0] digit_two;
  logic [CodeW-1:0] digit_three;
  logic [CodeW-1:0] digit_four;
  logic [LenW-1:0]  letter_count;

  modport source (
    output valid, output first_letter, output digit_one, output digit_two,
    output digit_three, output digit_four, output letter_count, input ready
  );
  modport sink (
    input valid, input first_letter, input digit_one, input digit_two,
    input digit_three, input digit_four, input letter_count, output ready
  );
endinterface

@@ src/sdx_classify.sv @@
// letter detection, case folding and code lookup for one byte
// depends on sdx_pkg
module sdx_classify import sdx_pkg::*; (
  input  logic [ByteW-1:0] byte_i,
  output sdx_class_t       class_o
);

  logic is_upper;
  logic is_lower;
  logic [CharW-1:0] folded;
  logic [4:0] idx;

  always_comb begin
    is_upper = (byte_i >= 8'h41) && (byte_i <= 8'h5A);
    is_lower = (byte_i >= 8'h61) && (byte_i <= 8'h7A);
    folded   = byte_i[CharW-1:0] | 7'h20;
    // 'a' has low five bits of one
    idx      = folded[4:0] - 5'd1;
    class_o.is_letter = is_upper || is_lower;
    class_o.lower     = folded;
    class_o.code      = letter_code(idx);
  end

endmodule

@@ src/sdx_word_state.sv @@
// per-word state: first letter, held digits, last code, letter count
// depends on sdx_pkg
module sdx_word_state import sdx_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  logic        end_i,
  input  sdx_class_t  class_i,
  output logic        emit_o,
  output sdx_result_t result_o
);

  logic [CharW-1:0]  first_q, first_d;
  logic [CodeW-1:0]  digits_q [NumDigits];
  logic [CodeW-1:0]  digits_d [NumDigits];
  logic [FillW-1:0]  filled_q, filled_d;
  logic [CodeW-1:0]  prev_q, prev_d;
  logic [CountW-1:0] letters_q, letters_d;

  logic pending;
  logic cut;
  logic take;
  logic [CountW+LenW-1:0] count_wide;

  always_comb begin
    pending    = letters_q != '0;
    cut        = letters_q >= CountW'(MaxWord);
    count_wide = {{LenW{1'b0}}, letters_q};

    result_o.first_letter = first_q;
    result_o.digit_one    = digits_q[0];
    result_o.digit_two    = digits_q[1];
    result_o.digit_three  = digits_q[2];
    result_o.digit_four   = digits_q[3];
    result_o.letter_count = count_wide[LenW-1:0];

    first_d   = first_q;
    digits_d  = digits_q;
    filled_d  = filled_q;
    prev_d    = prev_q;
    letters_d = letters_q;
    emit_o    = 1'b0;
    take      = (class_i.code != '0) && (class_i.code != prev_q)
             && (filled_q < FillW'(NumDigits));

    if (end_i || cut || !class_i.is_letter) begin
      // word closes; a full word also swallows this byte
      emit_o    = end_i ? pending : (cut || pending);
      first_d   = '0;
      digits_d  = '{default: '0};
      filled_d  = '0;
      prev_d    = '0;
      letters_d = '0;
    end else if (!pending) begin
      first_d   = class_i.lower;
      digits_d  = '{default: '0};
      filled_d  = '0;
      prev_d    = '0;
      letters_d = CountW'(1);
    end else begin
      if (take) begin
        digits_d[filled_q[1:0]] = class_i.code;
        filled_d = filled_q + FillW'(1);
        prev_d   = class_i.code;
      end else begin
        prev_d = '0;
      end
      letters_d = letters_q + CountW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q   <= '0;
      digits_q  <= '{default: '0};
      filled_q  <= '0;
      prev_q    <= '0;
      letters_q <= '0;
    end else if (step_i) begin
      first_q   <= first_d;
      digits_q  <= digits_d;
      filled_q  <= filled_d;
      prev_q    <= prev_d;
      letters_q <= letters_d;
    end
  end

endmodule

@@ src/word_soundex_encoder_unit.sv @@
// top level of the streaming soundex word coder
// depends on sdx_pkg, sdx_if, sdx_classify, sdx_word_state
//
//   channel  | dir | payload                                  | beat
//   ---------+-----+------------------------------------------+--------------------
//   char_i   | in  | text_byte, end_marker                    | one byte or end
//   code_o   | out | first_letter, digit_one..four, count     | one finished word
//
// one byte a cycle while no word waits untaken; a byte sits in the input register,
// and the word it closes, if any, enters the output register as the byte leaves
// while a word waits in the output register the input side still takes one
// byte into the input register, then holds it until the word is taken
// reset (rst_ni low, asynchronous) empties both registers and clears the word
// state; no clearing pass is needed
module word_soundex_encoder_unit import sdx_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  sdx_char_if.sink   char_i,
  sdx_code_if.source code_o
);

  // input register
  logic             in_vld_q;
  logic [ByteW-1:0] in_byte_q;
  logic             in_end_q;

  // output register
  logic        out_vld_q;
  sdx_result_t out_q;

  logic        advance;
  logic        step;
  logic        emit;
  sdx_class_t  cls;
  sdx_result_t result;

  // the stage moves whenever the result register is free or being drained
  assign advance      = !out_vld_q || code_o.ready;
  assign step         = in_vld_q && advance;
  assign char_i.ready = !in_vld_q || advance;

  sdx_classify u_classify (
    .byte_i  (in_byte_q),
    .class_o (cls)
  );

  sdx_word_state u_word_state (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .end_i    (in_end_q),
    .class_i  (cls),
    .emit_o   (emit),
    .result_o (result)
  );

  // control flops
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (char_i.ready) begin
        in_vld_q <= char_i.valid;
      end
      if (advance) begin
        out_vld_q <= step && emit;
      end
    end
  end

  // payload flops, no reset
  always_ff @(posedge clk_i) begin
    if (char_i.valid && char_i.ready) begin
      in_byte_q <= char_i.text_byte;
      in_end_q  <= char_i.end_marker;
    end
    if (step && emit) begin
      out_q <= result;
    end
  end

  assign code_o.valid        = out_vld_q;
  assign code_o.first_letter = out_q.first_letter;
  assign code_o.digit_one    = out_q.digit_one;
  assign code_o.digit_two    = out_q.digit_two;
  assign code_o.digit_three  = out_q.digit_three;
  assign code_o.digit_four   = out_q.digit_four;
  assign code_o.letter_count = out_q.letter_count;

endmodule

@@ tb/word_soundex_encoder_unit_test.sv @@
// self-checking bench for the streaming soundex word coder
// depends on sdx_pkg, sdx_if and word_soundex_encoder_unit
// a directed table and then random text are checked beat by beat against a local word model
module word_soundex_encoder_unit_test;
  import sdx_pkg::*;

  localparam int unsigned RandomItems  = 850;
  localparam int unsigned LongHold     = 200;    // cycles the sink refuses words once
  localparam int unsigned HoldAfter    = 300;    // random items before that hold-off
  localparam int unsigned DrainCycles  = 16;
  localparam int unsigned ReportLimit  = 10;
  localparam int unsigned TimeoutTicks = 4_000_000;
  localparam int unsigned NumRows      = 20;

  // soundex digit of each letter, a..z
  localparam logic [CodeW-1:0] LetterDigit [26] = '{
    0, 1, 2, 3, 0, 1, 2, 0, 0, 2, 2, 4, 5, 5, 0, 1, 2, 6, 2, 3, 0, 1, 0, 2, 0, 2
  };

  // how the sink paces its ready line during one stretch
  typedef enum int unsigned {
    PaceOpen,    // always ready
    PaceCoin,    // ready half the time
    PaceThird,   // ready one cycle in three
    PaceSparse   // ready one cycle in four on average
  } pace_e;

  // one line of the directed table; known rows carry a hand-written word
  typedef struct packed {
    logic [7:0]  text;
    logic        end_mark;
    logic [5:0]  copies;
    logic        known;
    sdx_result_t word;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;

  sdx_char_if char_bus ();
  sdx_code_if code_bus ();

  word_soundex_encoder_unit DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .char_i (char_bus),
    .code_o (code_bus)
  );

  // word model state
  logic [7:0]       word_first;
  logic [CodeW-1:0] word_digits [NumDigits];
  logic [2:0]       digits_held;
  logic [CodeW-1:0] last_code;
  int unsigned      letters_seen;

  sdx_result_t expected_words [$];

  int unsigned bytes_accepted  = 0;
  int unsigned effective_count = 0;
  int unsigned end_markers     = 0;
  int unsigned cut_words       = 0;
  int unsigned words_checked   = 0;
  int unsigned mismatch_count  = 0;
  int unsigned long_holds      = 0;
  int unsigned burst_left      = 8;
  bit          hold_request    = 1'b0;

  // directed table: edges of the byte range, case folding, the length cut,
  // end of input with and without a word, repeated codes and a full digit set
  stim_row_t directed_rows [NumRows] = '{
    '{8'h00, 1'b0, 6'd1,  1'b0, '0},                                  // zero byte, no word
    '{8'h80, 1'b1, 6'd1,  1'b0, '0},                                  // end, nothing pending
    '{8'h41, 1'b0, 6'd1,  1'b0, '0},                                  // 'A'
    '{8'hFF, 1'b0, 6'd1,  1'b1, '{7'h61, 3'd0, 3'd0, 3'd0, 3'd0, 5'd1}},
    '{8'h7A, 1'b0, 6'd1,  1'b0, '0},                                  // 'z'
    '{8'h5A, 1'b0, 6'd1,  1'b0, '0},                                  // 'Z'
    '{8'h62, 1'b1, 6'd1,  1'b1, '{7'h7A, 3'd2, 3'd0, 3'd0, 3'd0, 5'd2}},
    '{8'h40, 1'b0, 6'd1,  1'b0, '0},                                  // '@', no word
    '{8'h61, 1'b0, 6'd30, 1'b0, '0},                                  // full-length word
    '{8'h71, 1'b0, 6'd1,  1'b1, '{7'h61, 3'd0, 3'd0, 3'd0, 3'd0, 5'd30}},
    '{8'h78, 1'b0, 6'd1,  1'b0, '0},                                  // 'x' starts anew
    '{8'h62, 1'b0, 6'd1,  1'b0, '0},
    '{8'h66, 1'b0, 6'd1,  1'b0, '0},                                  // same code as 'b'
    '{8'h70, 1'b0, 6'd1,  1'b0, '0},
    '{8'h76, 1'b0, 6'd1,  1'b0, '0},
    '{8'h6C, 1'b0, 6'd1,  1'b0, '0},
    '{8'h6D, 1'b0, 6'd1,  1'b0, '0},
    '{8'h72, 1'b0, 6'd1,  1'b0, '0},                                  // digits already full
    '{8'h5B, 1'b0, 6'd1,  1'b0, '0},                                  // '[' closes it
    '{8'h60, 1'b0, 6'd1,  1'b0, '0}                                   // '`', no word
  };

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic bit is_alpha(input logic [7:0] b);
    return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
  endfunction

  function automatic logic [7:0] random_letter();
    logic [7:0] base;
    base = $urandom_range(0, 1) ? 8'h41 : 8'h61;
    return base + 8'($urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] random_non_letter();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (is_alpha(b));
    return b;
  endfunction

  task automatic clear_word();
    word_first   = '0;
    digits_held  = '0;
    last_code    = '0;
    letters_seen = 0;
    for (int i = 0; i < NumDigits; i++) word_digits[i] = '0;
  endtask

  // advance the word model by one beat; the word it closes, if any, is the
  // state as it stood before the beat
  task automatic soundex_step(input logic [7:0] b, input logic e, output bit emits,
                              output bit effective, output sdx_result_t word);
    logic [6:0]       low;
    logic [CodeW-1:0] c;
    word.first_letter = word_first[CharW-1:0];
    word.digit_one    = word_digits[0];
    word.digit_two    = word_digits[1];
    word.digit_three  = word_digits[2];
    word.digit_four   = word_digits[3];
    word.letter_count = LenW'(letters_seen);
    emits     = 1'b0;
    effective = 1'b0;
    if (e) begin
      emits = (letters_seen != 0);
      clear_word();
    end else if (letters_seen >= MaxWord) begin
      // byte after a full word is swallowed whatever it is
      emits = 1'b1;
      cut_words++;
      clear_word();
    end else if (!is_alpha(b)) begin
      emits = (letters_seen != 0);
      clear_word();
    end else begin
      effective = 1'b1;
      low = b[6:0] | 7'h20;
      if (letters_seen == 0) begin
        word_first   = {1'b0, low};
        letters_seen = 1;
      end else begin
        c = LetterDigit[int'(low) - 97];
        if (c != 0 && c != last_code && digits_held < NumDigits) begin
          word_digits[digits_held[1:0]] = c;
          digits_held++;
          last_code = c;
        end else begin
          // a letter whose code is not kept (uncoded, a repeat or no room left) forgets the last code
          last_code = '0;
        end
        letters_seen++;
      end
    end
    if (emits) effective = 1'b1;
  endtask

  // present one beat, wait for it to be taken, then book the expected word;
  // bursts of beats are separated by random gaps with valid low
  task automatic offer_beat(input logic [7:0] b, input logic e, input bit known,
                            input sdx_result_t known_word);
    bit          emits;
    bit          effective;
    sdx_result_t word;
    int unsigned gap;
    char_bus.valid      <= 1'b1;
    char_bus.text_byte  <= b;
    char_bus.end_marker <= e;
    do @(posedge clk_i); while (!char_bus.ready);
    soundex_step(b, e, emits, effective, word);
    if (known) expected_words.push_back(known_word);
    else if (emits) expected_words.push_back(word);
    bytes_accepted++;
    if (e) end_markers++;
    if (effective) effective_count++;
    burst_left--;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 4) : $urandom_range(10, 30);
      char_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
    end
  endtask

  // sink side: stretches of random pacing, plus one long hold-off on request
  initial begin : sink_pacing
    pace_e       pace;
    int unsigned span;
    code_bus.ready <= 1'b0;
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        for (int k = 0; k < LongHold; k++) begin
          @(posedge clk_i);
          code_bus.ready <= 1'b0;
        end
        long_holds++;
      end
      pace = pace_e'($urandom_range(0, 3));
      span = $urandom_range(4, 40);
      for (int k = 0; k < span; k++) begin
        @(posedge clk_i);
        case (pace)
          PaceOpen:  code_bus.ready <= 1'b1;
          PaceCoin:  code_bus.ready <= 1'($urandom_range(0, 1));
          PaceThird: code_bus.ready <= (k % 3 == 0);
          default:   code_bus.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // word check: every taken word against the oldest booked one
  always @(posedge clk_i) begin : word_check
    sdx_result_t got;
    sdx_result_t want;
    if (rst_ni && code_bus.valid && code_bus.ready) begin
      got.first_letter = code_bus.first_letter;
      got.digit_one    = code_bus.digit_one;
      got.digit_two    = code_bus.digit_two;
      got.digit_three  = code_bus.digit_three;
      got.digit_four   = code_bus.digit_four;
      got.letter_count = code_bus.letter_count;
      if (expected_words.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= ReportLimit)
          $display("unexpected word %c %0d%0d%0d%0d len %0d with none pending",
                   got.first_letter, got.digit_one, got.digit_two, got.digit_three,
                   got.digit_four, got.letter_count);
      end else begin
        want = expected_words.pop_front();
        words_checked++;
        if (got.first_letter !== want.first_letter || got.digit_one !== want.digit_one ||
            got.digit_two !== want.digit_two || got.digit_three !== want.digit_three ||
            got.digit_four !== want.digit_four || got.letter_count !== want.letter_count)
        begin
          mismatch_count++;
          if (mismatch_count <= ReportLimit)
            $display("word %0d: expected %c %0d%0d%0d%0d len %0d, got %c %0d%0d%0d%0d len %0d",
                     words_checked, want.first_letter, want.digit_one, want.digit_two,
                     want.digit_three, want.digit_four, want.letter_count,
                     got.first_letter, got.digit_one, got.digit_two, got.digit_three,
                     got.digit_four, got.letter_count);
        end
      end
    end
  end

  initial begin : watchdog
    #(TimeoutTicks);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : text_source
    int unsigned random_base;
    int unsigned pick;
    int unsigned shape;
    int unsigned len;
    bit          hold_armed;
    hold_armed          = 1'b0;
    rst_ni              = 1'b0;
    char_bus.valid      <= 1'b0;
    char_bus.text_byte  <= '0;
    char_bus.end_marker <= 1'b0;
    clear_word();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < NumRows; r++)
      for (int n = 0; n < directed_rows[r].copies; n++)
        offer_beat(directed_rows[r].text, directed_rows[r].end_mark,
                   directed_rows[r].known && (n == directed_rows[r].copies - 1),
                   directed_rows[r].word);

    // random text: mostly words of mixed case, some near the length cut,
    // some end markers, some stray bytes
    random_base = effective_count;
    while (effective_count - random_base < RandomItems) begin
      if (!hold_armed && effective_count - random_base > HoldAfter) begin
        hold_request = 1'b1;
        hold_armed   = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 72) begin
        shape = $urandom_range(0, 99);
        if (shape < 85) len = $urandom_range(1, 8);
        else if (shape < 93) len = $urandom_range(9, 24);
        else len = $urandom_range(MaxWord - 2, MaxWord + 3);
        for (int n = 0; n < len; n++) offer_beat(random_letter(), 1'b0, 1'b0, '0);
        if ($urandom_range(0, 6) == 0) offer_beat(8'($urandom), 1'b1, 1'b0, '0);
        else offer_beat(random_non_letter(), 1'b0, 1'b0, '0);
      end else if (pick < 80) begin
        offer_beat(8'($urandom), 1'b1, 1'b0, '0);
      end else if (pick < 92) begin
        len = $urandom_range(1, 4);
        for (int n = 0; n < len; n++) offer_beat(8'($urandom), 1'b0, 1'b0, '0);
      end else begin
        // word right at the limit, then whatever byte follows
        for (int n = 0; n < MaxWord; n++) offer_beat(random_letter(), 1'b0, 1'b0, '0);
        offer_beat(8'($urandom), 1'($urandom_range(0, 1)), 1'b0, '0);
      end
    end
    offer_beat(8'($urandom), 1'b1, 1'b0, '0);
    char_bus.valid <= 1'b0;

    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (expected_words.size() != 0)
      $display("%0d words still pending at the end", expected_words.size());
    $display("ran %0d bytes with %0d end markers, compared %0d words, %0d cut at the limit",
             bytes_accepted, end_markers, words_checked, cut_words);
    $display("sink held off %0d time(s) for %0d cycles, %0d mismatches", long_holds, LongHold,
             mismatch_count);
    if (mismatch_count == 0 && expected_words.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
